@@ hw/rtl/csc_pkg.sv @@
// shared types, constants and arithmetic helpers for the coordinate converter
`timescale 1ns / 1ps

package csc_pkg;

    // cordic iterations per unit and fraction bits of the external format
    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;

    // internal formats: lengths carry guard bits, angles have 30 fraction bits
    localparam int GUARD   = 8;
    localparam int ANG_FRAC = 30;
    localparam int ANG_SH  = ANG_FRAC - FRACTION_BITS;
    localparam int LW      = 44;
    localparam int AW      = 36;
    localparam int PW      = LW + 16;

    // angle reduction: magnitude of the scaled input and reciprocal estimate widths
    localparam int AIW = 33 + ANG_SH;
    localparam int RW  = 24;
    localparam int QW  = 24;
    localparam int MW  = 33 + RW;

    typedef logic signed [LW-1:0] len_t;
    typedef logic signed [AW-1:0] ang_t;
    typedef logic signed [PW-1:0] prod_t;

    // gain compensation split into a high and a low partial coefficient
    localparam longint GAIN_K = 652032874;
    localparam logic signed [15:0] GAIN_HI = 16'(GAIN_K >> 15);
    localparam logic signed [15:0] GAIN_LO = 16'(GAIN_K & 32767);

    localparam ang_t PI_Q      = ang_t'(64'd3373259426);
    localparam ang_t HALF_PI_Q = ang_t'(64'd1686629713);
    localparam ang_t TWO_PI_Q  = ang_t'(64'd6746518852);
    localparam logic [33:0] TWO_PI_U = 34'd6746518852;

    // floor(2^(32+ANG_SH) / (2pi * 2^30)) for quotient estimate of the angle reduction
    localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + ANG_SH)) / 64'd6746518852;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

    localparam len_t OUT_MAX = len_t'(64'sd2147483647);
    localparam len_t OUT_MIN = ~OUT_MAX;

    typedef enum logic [1:0] {
        CMD_CYL_TO_CART = 2'd0,
        CMD_CART_TO_CYL = 2'd1,
        CMD_SPH_TO_CART = 2'd2,
        CMD_CART_TO_SPH = 2'd3
    } cmd_t;

    // side data that travels alongside the cordic pipeline
    typedef struct packed {
        cmd_t        cmd;
        logic        zero;
        logic [31:0] third;
        len_t        len_a;
        len_t        len_b;
        ang_t        ang;
    } side_t;

    // atan(2^-i) in 30-bit fraction radians, truncated
    function automatic ang_t atan_tab(input logic [4:0] i);
        ang_t v;
        unique case (i)
            5'd0:  v = ang_t'(64'h3243F6A8);
            5'd1:  v = ang_t'(64'h1DAC6705);
            5'd2:  v = ang_t'(64'h0FADBAFC);
            5'd3:  v = ang_t'(64'h07F56EA6);
            5'd4:  v = ang_t'(64'h03FEAB76);
            5'd5:  v = ang_t'(64'h01FFD55B);
            5'd6:  v = ang_t'(64'h00FFFAAA);
            5'd7:  v = ang_t'(64'h007FFF55);
            5'd8:  v = ang_t'(64'h003FFFEA);
            5'd9:  v = ang_t'(64'h001FFFFD);
            5'd10: v = ang_t'(64'h000FFFFF);
            5'd11: v = ang_t'(64'h0007FFFF);
            5'd12: v = ang_t'(64'h0003FFFF);
            5'd13: v = ang_t'(64'h0001FFFF);
            5'd14: v = ang_t'(64'h0000FFFF);
            5'd15: v = ang_t'(64'h00007FFF);
            5'd16: v = ang_t'(64'h00003FFF);
            5'd17: v = ang_t'(64'h00001FFF);
            5'd18: v = ang_t'(64'h00000FFF);
            5'd19: v = ang_t'(64'h000007FF);
            5'd20: v = ang_t'(64'h000003FF);
            5'd21: v = ang_t'(64'h000001FF);
            5'd22: v = ang_t'(64'h000000FF);
            5'd23: v = ang_t'(64'h0000007F);
            5'd24: v = ang_t'(64'h0000003F);
            5'd25: v = ang_t'(64'h0000001F);
            5'd26: v = ang_t'(64'h0000000F);
            5'd27: v = ang_t'(64'h00000007);
            5'd28: v = ang_t'(64'h00000003);
            5'd29: v = ang_t'(64'h00000001);
            default: v = '0;
        endcase
        return v;
    endfunction

    // gain multiply, first half: high partial product
    function automatic prod_t mulk_hi(input len_t v);
        return prod_t'(v) * prod_t'(GAIN_HI);
    endfunction

    // gain multiply, first half: low partial product pre-shifted
    function automatic prod_t mulk_lo(input len_t v);
        return (prod_t'(v) * prod_t'(GAIN_LO)) >>> 15;
    endfunction

    // gain multiply, second half: combine partials
    function automatic len_t mulk_sum(input prod_t h, input prod_t l);
        prod_t s;
        s = (h + l) >>> 15;
        return len_t'(s[LW-1:0]);
    endfunction

    // round a length to the output format; msb is the saturation mark
    function automatic logic [32:0] len_out(input len_t v);
        len_t r;
        logic [32:0] o;
        r = (v + (len_t'(1) <<< (GUARD - 1))) >>> GUARD;
        if (r > OUT_MAX)
            o = {1'b1, 32'h7FFF_FFFF};
        else if (r < OUT_MIN)
            o = {1'b1, 32'h8000_0000};
        else
            o = {1'b0, r[31:0]};
        return o;
    endfunction

    // clamp and round an angle to the output format
    function automatic logic [31:0] ang_out(input ang_t a, input logic floor_zero);
        ang_t c;
        ang_t lo;
        lo = floor_zero ? ang_t'(0) : -PI_Q;
        c = a;
        if (c < lo)
            c = lo;
        if (c > PI_Q)
            c = PI_Q;
        c = (c + (ang_t'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
        return c[31:0];
    endfunction

endpackage

@@ hw/rtl/csc_cordic.sv @@
// pipelined cordic unit, rotation or vectoring per item, one iteration per stage
`timescale 1ns / 1ps

module csc_cordic
    import csc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_vec,
    input  len_t  in_x,
    input  len_t  in_y,
    input  ang_t  in_z,
    input  side_t in_side,
    output logic  out_valid,
    output len_t  out_x,
    output len_t  out_y,
    output ang_t  out_z,
    output side_t out_side
);

    logic  valid_reg [0:CORDIC_STEPS];
    logic  vec_reg   [0:CORDIC_STEPS];
    logic  flip_reg  [0:CORDIC_STEPS];
    logic  zero_reg  [0:CORDIC_STEPS];
    len_t  x_reg     [0:CORDIC_STEPS];
    len_t  y_reg     [0:CORDIC_STEPS];
    ang_t  z_reg     [0:CORDIC_STEPS];
    side_t side_reg  [0:CORDIC_STEPS];

    len_t  x_next    [0:CORDIC_STEPS];
    len_t  y_next    [0:CORDIC_STEPS];
    ang_t  z_next    [0:CORDIC_STEPS];
    logic  flip_next;
    logic  zero_next;

    logic  out_valid_reg;
    len_t  out_x_reg;
    len_t  out_y_reg;
    ang_t  out_z_reg;
    side_t out_side_reg;

    // entry: quadrant fix for vectoring, half-turn fold for rotation
    always_comb
    begin
        x_next[0] = in_x;
        y_next[0] = in_y;
        z_next[0] = in_z;
        flip_next = 1'b0;
        zero_next = (in_x == '0) && (in_y == '0);
        if (in_vec)
        begin
            z_next[0] = '0;
            if (in_x < 0)
            begin
                if (in_y >= 0)
                begin
                    x_next[0] = in_y;
                    y_next[0] = -in_x;
                    z_next[0] = HALF_PI_Q;
                end
                else
                begin
                    x_next[0] = -in_y;
                    y_next[0] = in_x;
                    z_next[0] = -HALF_PI_Q;
                end
            end
        end
        else
        begin
            if (in_z > HALF_PI_Q)
            begin
                z_next[0] = in_z - PI_Q;
                flip_next = 1'b1;
            end
            else if (in_z < -HALF_PI_Q)
            begin
                z_next[0] = in_z + PI_Q;
                flip_next = 1'b1;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic dir;
        always_comb
        begin
            dir = vec_reg[i] ? (y_reg[i] < 0) : (z_reg[i] >= 0);
            if (dir)
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - atan_tab(5'(i));
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + atan_tab(5'(i));
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STEPS; k++)
                valid_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= CORDIC_STEPS; k++)
                valid_reg[k] <= valid_reg[k-1];
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    // data chain
    always_ff @(posedge clk)
    begin
        vec_reg[0]  <= in_vec;
        flip_reg[0] <= flip_next;
        zero_reg[0] <= zero_next;
        side_reg[0] <= in_side;
        for (int k = 0; k <= CORDIC_STEPS; k++)
        begin
            x_reg[k] <= x_next[k];
            y_reg[k] <= y_next[k];
            z_reg[k] <= z_next[k];
        end
        for (int k = 1; k <= CORDIC_STEPS; k++)
        begin
            vec_reg[k]  <= vec_reg[k-1];
            flip_reg[k] <= flip_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
        // exit: undo half-turn fold, zero vector gives zero angle
        out_x_reg <= (!vec_reg[CORDIC_STEPS] && flip_reg[CORDIC_STEPS])
                   ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        out_y_reg <= (!vec_reg[CORDIC_STEPS] && flip_reg[CORDIC_STEPS])
                   ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        out_z_reg <= (vec_reg[CORDIC_STEPS] && zero_reg[CORDIC_STEPS])
                   ? ang_t'(0) : z_reg[CORDIC_STEPS];
        out_side_reg <= side_reg[CORDIC_STEPS];
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_side  = out_side_reg;

endmodule

@@ hw/rtl/coordinate_system_converter.sv @@
// coordinate converter top level: input scaling, two cordic units, output rounding
//
//  port group                       | dir | meaning
//  start, busy                      | i/o | request strobe in, busy out held low
//  command, first/second/third_value| in  | command and vector, Q15.16
//  done                             | out | one-cycle result strobe
//  result_first/second/third, flag  | out | converted vector and range flag
//
// one request per cycle; results pass s0-s3, the first cordic unit, gain stages m1 and m2,
// the second cordic unit and the output register, each unit one iteration per stage
// busy never rises; the receiver cannot stall, so done simply follows the pipe
// reset clears only the valid bits; payload registers are not reset
`timescale 1ns / 1ps

module coordinate_system_converter
    import csc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] first_value,
    input  logic signed [31:0] second_value,
    input  logic signed [31:0] third_value,
    output logic               done,
    output logic signed [31:0] result_first,
    output logic signed [31:0] result_second,
    output logic signed [31:0] result_third,
    output logic               range_flag
);

    // stage 0: input capture
    logic               s0_valid_reg;
    side_t              s0_side_reg;
    logic signed [31:0] s0_val_reg [0:2];

    // stage 1: gain partial products, angle quotient estimate
    logic               s1_valid_reg;
    side_t              s1_side_reg;
    prod_t              s1_hi_reg [0:2];
    prod_t              s1_lo_reg [0:2];
    logic [AIW-1:0]     s1_absa_reg [1:2];
    logic [QW-1:0]      s1_q_reg [1:2];
    logic               s1_neg_reg [1:2];
    logic [AIW-1:0]     s1_absa_next [1:2];
    logic [QW-1:0]      s1_q_next [1:2];
    logic signed [32:0] s1_ext [1:2];
    logic [32:0]        s1_mag [1:2];

    // stage 2: scaled lengths, angle remainder
    logic               s2_valid_reg;
    side_t              s2_side_reg;
    len_t               s2_len_reg [0:2];
    logic [AIW-1:0]     s2_rem_reg [1:2];
    logic               s2_neg_reg [1:2];

    // stage 3: reduced angles
    logic               s3_valid_reg;
    side_t              s3_side_reg;
    len_t               s3_len_reg [0:2];
    ang_t               s3_ang_reg [1:2];
    ang_t               s3_ang_next [1:2];
    logic [AIW-1:0]     s3_rem [1:2];

    // first cordic unit
    logic  u1_in_vec;
    len_t  u1_in_y;
    ang_t  u1_in_z;
    side_t u1_in_side;
    logic  u1_valid;
    len_t  u1_x;
    len_t  u1_y;
    ang_t  u1_z;
    side_t u1_side;

    // gain stages between the units
    logic  m1_valid_reg;
    side_t m1_side_reg;
    side_t m1_side_next;
    prod_t m1_hi_reg;
    prod_t m1_lo_reg;
    len_t  m1_l2_reg;
    ang_t  m1_a2_reg;
    len_t  m1_sel;
    logic  m2_valid_reg;
    side_t m2_side_reg;
    len_t  m2_mk_reg;
    len_t  m2_l2_reg;
    ang_t  m2_a2_reg;

    // second cordic unit
    logic  u2_in_vec;
    len_t  u2_in_x;
    len_t  u2_in_y;
    logic  u2_valid;
    len_t  u2_x;
    len_t  u2_y;
    ang_t  u2_z;
    side_t u2_side;

    // output register
    logic        done_reg;
    logic [31:0] r1_reg;
    logic [31:0] r2_reg;
    logic [31:0] r3_reg;
    logic        flag_reg;
    logic [31:0] r1_next;
    logic [31:0] r2_next;
    logic [31:0] r3_next;
    logic        flag_next;
    logic [32:0] lo_a;
    logic [32:0] lo_b;
    logic [32:0] lo_p;
    logic [32:0] lo_q;

    // every request is taken at once
    assign busy = 1'b0;

    // stage 1 angle quotient estimate from input magnitude
    always_comb
    begin
        for (int k = 1; k <= 2; k++)
        begin
            s1_ext[k]       = 33'(s0_val_reg[k]);
            s1_mag[k]       = (s1_ext[k] < 0) ? 33'(-s1_ext[k]) : 33'(s1_ext[k]);
            s1_absa_next[k] = AIW'(s1_mag[k]) << ANG_SH;
            s1_q_next[k]    = QW'((MW'(s1_mag[k]) * MW'(RECIP)) >> 32);
        end
    end

    // stage 3 remainder fix-up, sign and wrap into minus pi to pi
    always_comb
    begin
        for (int k = 1; k <= 2; k++)
        begin
            s3_rem[k] = (s2_rem_reg[k] >= AIW'(TWO_PI_U))
                      ? s2_rem_reg[k] - AIW'(TWO_PI_U) : s2_rem_reg[k];
            s3_ang_next[k] = ang_t'(s3_rem[k][33:0]);
            if (s2_neg_reg[k])
                s3_ang_next[k] = -s3_ang_next[k];
            if (s3_ang_next[k] > PI_Q)
                s3_ang_next[k] = s3_ang_next[k] - TWO_PI_Q;
            else if (s3_ang_next[k] < -PI_Q)
                s3_ang_next[k] = s3_ang_next[k] + TWO_PI_Q;
        end
    end

    // valid chain of the front, gain and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m1_valid_reg <= u1_valid;
            m2_valid_reg <= m1_valid_reg;
            done_reg     <= u2_valid;
        end
    end

    // front data path
    always_ff @(posedge clk)
    begin
        s0_side_reg.cmd   <= cmd_t'(command);
        s0_side_reg.zero  <= (first_value == '0) && (second_value == '0)
                          && (third_value == '0);
        s0_side_reg.third <= third_value;
        s0_side_reg.len_a <= '0;
        s0_side_reg.len_b <= '0;
        s0_side_reg.ang   <= '0;
        s0_val_reg[0]     <= first_value;
        s0_val_reg[1]     <= second_value;
        s0_val_reg[2]     <= third_value;

        s1_side_reg <= s0_side_reg;
        for (int k = 0; k <= 2; k++)
        begin
            s1_hi_reg[k] <= mulk_hi(len_t'(s0_val_reg[k]) <<< GUARD);
            s1_lo_reg[k] <= mulk_lo(len_t'(s0_val_reg[k]) <<< GUARD);
        end
        for (int k = 1; k <= 2; k++)
        begin
            s1_absa_reg[k] <= s1_absa_next[k];
            s1_q_reg[k]    <= s1_q_next[k];
            s1_neg_reg[k]  <= s0_val_reg[k][31];
        end

        s2_side_reg <= s1_side_reg;
        for (int k = 0; k <= 2; k++)
            s2_len_reg[k] <= mulk_sum(s1_hi_reg[k], s1_lo_reg[k]);
        for (int k = 1; k <= 2; k++)
        begin
            s2_rem_reg[k] <= s1_absa_reg[k]
                           - AIW'(MW'(s1_q_reg[k]) * MW'(TWO_PI_U));
            s2_neg_reg[k] <= s1_neg_reg[k];
        end

        s3_side_reg <= s2_side_reg;
        for (int k = 0; k <= 2; k++)
            s3_len_reg[k] <= s2_len_reg[k];
        for (int k = 1; k <= 2; k++)
            s3_ang_reg[k] <= s3_ang_next[k];
    end

    // first unit operands: x with y or z for vectoring, radius with angle for rotation
    always_comb
    begin
        u1_in_vec = (s3_side_reg.cmd == CMD_CART_TO_CYL)
                 || (s3_side_reg.cmd == CMD_CART_TO_SPH);
        u1_in_y   = '0;
        if (s3_side_reg.cmd == CMD_CART_TO_CYL)
            u1_in_y = s3_len_reg[1];
        else if (s3_side_reg.cmd == CMD_CART_TO_SPH)
            u1_in_y = s3_len_reg[2];
        u1_in_z   = (s3_side_reg.cmd == CMD_SPH_TO_CART) ? s3_ang_reg[2] : s3_ang_reg[1];
        u1_in_side       = s3_side_reg;
        u1_in_side.len_a = s3_len_reg[1];
        u1_in_side.ang   = s3_ang_reg[1];
    end

    csc_cordic u_cordic_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_vec    (u1_in_vec),
        .in_x      (s3_len_reg[0]),
        .in_y      (u1_in_y),
        .in_z      (u1_in_z),
        .in_side   (u1_in_side),
        .out_valid (u1_valid),
        .out_x     (u1_x),
        .out_y     (u1_y),
        .out_z     (u1_z),
        .out_side  (u1_side)
    );

    // gain compensation of the first unit's result feeding the second unit
    assign m1_sel = (u1_side.cmd == CMD_CART_TO_SPH) ? u1_x : u1_y;

    // side data carries the first unit's result onward
    always_comb
    begin
        m1_side_next       = u1_side;
        m1_side_next.len_a = u1_x;
        m1_side_next.len_b = u1_y;
        m1_side_next.ang   = u1_z;
    end

    always_ff @(posedge clk)
    begin
        m1_hi_reg   <= mulk_hi(m1_sel);
        m1_lo_reg   <= mulk_lo(m1_sel);
        m1_l2_reg   <= u1_side.len_a;
        m1_a2_reg   <= u1_side.ang;
        m1_side_reg <= m1_side_next;

        m2_mk_reg   <= mulk_sum(m1_hi_reg, m1_lo_reg);
        m2_l2_reg   <= m1_l2_reg;
        m2_a2_reg   <= m1_a2_reg;
        m2_side_reg <= m1_side_reg;
    end

    // second unit operands: y-axis vectoring for spherical, azimuth rotation otherwise
    always_comb
    begin
        u2_in_vec = (m2_side_reg.cmd == CMD_CART_TO_SPH);
        u2_in_x   = u2_in_vec ? m2_l2_reg : m2_mk_reg;
        u2_in_y   = u2_in_vec ? m2_mk_reg : len_t'(0);
    end

    csc_cordic u_cordic_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid_reg),
        .in_vec    (u2_in_vec),
        .in_x      (u2_in_x),
        .in_y      (u2_in_y),
        .in_z      (m2_a2_reg),
        .in_side   (m2_side_reg),
        .out_valid (u2_valid),
        .out_x     (u2_x),
        .out_y     (u2_y),
        .out_z     (u2_z),
        .out_side  (u2_side)
    );

    // output selection, rounding and saturation
    always_comb
    begin
        lo_a = len_out(u2_side.len_a);
        lo_b = len_out(u2_side.len_b);
        lo_p = len_out(u2_x);
        lo_q = len_out(u2_y);
        unique case (u2_side.cmd)
            CMD_CYL_TO_CART:
            begin
                r1_next   = lo_a[31:0];
                r2_next   = lo_b[31:0];
                r3_next   = u2_side.third;
                flag_next = lo_a[32] | lo_b[32];
            end
            CMD_CART_TO_CYL:
            begin
                r1_next   = lo_a[31:0];
                r2_next   = ang_out(u2_side.ang, 1'b0);
                r3_next   = u2_side.third;
                flag_next = u2_side.zero | lo_a[32];
            end
            CMD_SPH_TO_CART:
            begin
                r1_next   = lo_p[31:0];
                r2_next   = lo_a[31:0];
                r3_next   = lo_q[31:0];
                flag_next = lo_p[32] | lo_a[32] | lo_q[32];
            end
            CMD_CART_TO_SPH:
            begin
                r1_next   = lo_p[31:0];
                r2_next   = ang_out(u2_side.ang, 1'b0);
                r3_next   = ang_out(u2_z, 1'b1);
                flag_next = u2_side.zero | lo_p[32];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        r3_reg   <= r3_next;
        flag_reg <= flag_next;
    end

    assign done          = done_reg;
    assign result_first  = r1_reg;
    assign result_second = r2_reg;
    assign result_third  = r3_reg;
    assign range_flag    = flag_reg;

endmodule
